// ----- rtl/bfg_pkg.sv -----
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared types, register indexes and defaults of the bilinear field gather.
// ----------------------------------------------------------------------------
package bfg_pkg;

    localparam int GRID_W_DEF    = 64;
    localparam int GRID_H_DEF    = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Depth of the queue between front and back part
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH    = 3'd4;

    localparam logic [31:0] INV_SPACING_RST = 32'd65536;
    localparam logic [6:0]  WRAP_WIDTH_RST  = 7'd64;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        inv_x;
        logic [31:0]        inv_y;
        logic [6:0]         wrap;
    } t_cfg;

    // One classified beat from the front part
    typedef struct packed {
        logic               interp;
        logic               load_ok;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic signed [31:0] cell_value;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
    } t_item;

    typedef struct packed {
        logic signed [31:0] field_value;
        logic [5:0]         index_x;
        logic [5:0]         index_y;
        logic [16:0]        weight_00;
        logic [16:0]        weight_01;
        logic [16:0]        weight_10;
        logic [16:0]        weight_11;
        logic               out_of_range;
    } t_result;

endpackage

// ----- rtl/bilinear_field_gather_core.sv -----
// ----------------------------------------------------------------------------
// bilinear_field_gather_core
// Load a 2D field grid cell by cell, then gather bilinearly blended values.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, loads and interpolations alike; the back part
//   drains the queue every cycle, so busy stays low.
// An accepted interpolation passes the front register, queue, scale multiply,
//   locate, bank read, weight multiply and sum registers before o_valid rises.
// Reset: synchronous, active low; clears control state, loads the register defaults.
//   Grid contents are undefined until loaded. Results cannot be stalled: one cycle each.
// ----------------------------------------------------------------------------
module bilinear_field_gather_core #(
    parameter int GRID_W    = bfg_pkg::GRID_W_DEF,
    parameter int GRID_H    = bfg_pkg::GRID_H_DEF,
    parameter int FRAC_BITS = bfg_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic signed [31:0]               i_pos_x,
    input  logic signed [31:0]               i_pos_y,
    input  logic [5:0]                       i_cell_x,
    input  logic [5:0]                       i_cell_y,
    input  logic signed [31:0]               i_cell_value,

    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bfg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bfg_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    // result channel
    output logic                             o_valid,
    output logic signed [31:0]               o_field_value,
    output logic [5:0]                       o_index_x,
    output logic [5:0]                       o_index_y,
    output logic [16:0]                      o_weight_00,
    output logic [16:0]                      o_weight_01,
    output logic [16:0]                      o_weight_10,
    output logic [16:0]                      o_weight_11,
    output logic                             o_out_of_range
);

    bfg_pkg::t_cfg    r_cfg;
    logic             accept;
    logic             front_push;
    bfg_pkg::t_item   front_item;
    logic             q_valid;
    bfg_pkg::t_item   q_item;
    logic             q_almost_full;
    logic             back_valid;
    bfg_pkg::t_result back_result;

    // Hold off new beats once the queue nears full; the beat in the front
    // register still finds a free slot.
    assign busy   = q_almost_full;
    assign accept = start && !busy;

    // Config registers; writes must come only while the block is idle (unenforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.inv_x    <= bfg_pkg::INV_SPACING_RST;
            r_cfg.inv_y    <= bfg_pkg::INV_SPACING_RST;
            r_cfg.wrap     <= bfg_pkg::WRAP_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bfg_pkg::CFG_ORIGIN_X:      r_cfg.origin_x <= i_cfg_data;
                bfg_pkg::CFG_ORIGIN_Y:      r_cfg.origin_y <= i_cfg_data;
                bfg_pkg::CFG_INV_SPACING_X: r_cfg.inv_x    <= i_cfg_data;
                bfg_pkg::CFG_INV_SPACING_Y: r_cfg.inv_y    <= i_cfg_data;
                bfg_pkg::CFG_WRAP_WIDTH:    r_cfg.wrap     <= i_cfg_data[6:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Front part: register the beat, subtract the origin, classify loads
    bfg_front #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_value (i_cell_value),
        .i_cfg        (r_cfg),
        .o_push       (front_push),
        .o_item       (front_item)
    );

    // Queue that decouples front from back
    bfg_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (front_push),
        .i_item        (front_item),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .o_almost_full (q_almost_full)
    );

    // Back part: scale, locate, write or read the banks, blend
    bfg_back #(
        .GRID_W    (GRID_W),
        .GRID_H    (GRID_H),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .i_cfg    (r_cfg),
        .o_valid  (back_valid),
        .o_result (back_result)
    );

    assign o_valid        = back_valid;
    assign o_field_value  = back_result.field_value;
    assign o_index_x      = back_result.index_x;
    assign o_index_y      = back_result.index_y;
    assign o_weight_00    = back_result.weight_00;
    assign o_weight_01    = back_result.weight_01;
    assign o_weight_10    = back_result.weight_10;
    assign o_weight_11    = back_result.weight_11;
    assign o_out_of_range = back_result.out_of_range;

endmodule

// ----- rtl/bfg_front.sv -----
// ----------------------------------------------------------------------------
// bfg_front
// Accept a beat, take the position relative to the origin, classify loads.
// ----------------------------------------------------------------------------
module bfg_front #(
    parameter int GRID_W = bfg_pkg::GRID_W_DEF,
    parameter int GRID_H = bfg_pkg::GRID_H_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_operation,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic signed [31:0] i_cell_value,
    input  bfg_pkg::t_cfg      i_cfg,
    output logic               o_push,
    output bfg_pkg::t_item     o_item
);

    logic           r_push;
    bfg_pkg::t_item r_item;
    bfg_pkg::t_item n_item;

    always_comb begin
        n_item            = '0;
        n_item.interp     = (i_operation == bfg_pkg::OP_INTERP);
        n_item.load_ok    = (32'(i_cell_x) < 32'(GRID_W)) && (32'(i_cell_y) < 32'(GRID_H));
        n_item.cell_x     = i_cell_x;
        n_item.cell_y     = i_cell_y;
        n_item.cell_value = i_cell_value;
        n_item.d_x        = 33'(i_pos_x) - 33'(i_cfg.origin_x);
        n_item.d_y        = 33'(i_pos_y) - 33'(i_cfg.origin_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
        end else begin
            r_push <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_push;
    assign o_item = r_item;

endmodule

// ----- rtl/bfg_queue.sv -----
// ----------------------------------------------------------------------------
// bfg_queue
// Short FIFO between front and back part; the back part drains a beat per cycle.
// ----------------------------------------------------------------------------
module bfg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bfg_pkg::t_item i_item,
    output logic           o_valid,
    output bfg_pkg::t_item o_item,
    output logic           o_almost_full
);

    localparam int DEPTH = bfg_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    bfg_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           pop;

    assign pop = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid       = pop;
    assign o_item        = r_mem[r_rd_ptr];
    assign o_almost_full = (r_count >= CW'(DEPTH - 1));

endmodule

// ----- rtl/bfg_back.sv -----
// ----------------------------------------------------------------------------
// bfg_back
// Scale, locate, store loads or read four neighbors from two row banks, blend.
// ----------------------------------------------------------------------------
module bfg_back #(
    parameter int GRID_W    = bfg_pkg::GRID_W_DEF,
    parameter int GRID_H    = bfg_pkg::GRID_H_DEF,
    parameter int FRAC_BITS = bfg_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bfg_pkg::t_item   i_item,
    input  bfg_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output bfg_pkg::t_result o_result
);

    localparam int F     = FRAC_BITS;
    localparam int XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int ROWS0 = (GRID_H + 1) / 2;
    localparam int ROWS1 = GRID_H / 2;
    localparam int RW0   = (ROWS0 > 1) ? $clog2(ROWS0) : 1;
    localparam int RW1   = (ROWS1 > 1) ? $clog2(ROWS1) : 1;
    localparam int AW0   = RW0 + XW;
    localparam int AW1   = RW1 + XW;
    localparam int DEP0  = ROWS0 * (2 ** XW);
    localparam int DEP1  = ROWS1 * (2 ** XW);
    localparam int IW    = 64 - 2 * F;
    localparam int WW    = F + 1;
    localparam int PQW   = 2 * WW;
    localparam int PW    = F + 34;
    localparam int SW    = F + 36;
    localparam logic [WW-1:0] ONE_W = {1'b1, {F{1'b0}}};

    // Row banks: even rows in bank 0, odd rows in bank 1
    logic signed [31:0] r_bank0 [DEP0];
    logic signed [31:0] r_bank1 [DEP1];

    // ---- stage 1: scale by the inverse spacing
    logic               r_s1_v;
    logic               r_s1_interp;
    logic               r_s1_load;
    logic [63:0]        r_s1_prod_x;
    logic [63:0]        r_s1_prod_y;
    logic               r_s1_neg_x;
    logic               r_s1_neg_y;
    logic [5:0]         r_s1_cell_x;
    logic [5:0]         r_s1_cell_y;
    logic signed [31:0] r_s1_cell_value;

    logic signed [32:0] neg_dx;
    logic signed [32:0] neg_dy;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;

    always_comb begin
        neg_dx = -i_item.d_x;
        neg_dy = -i_item.d_y;
        mag_x  = i_item.d_x[32] ? neg_dx[31:0] : i_item.d_x[31:0];
        mag_y  = i_item.d_y[32] ? neg_dy[31:0] : i_item.d_y[31:0];
    end

    // ---- stage 2: locate cell, form addresses
    logic               r_s2_v;
    logic               r_s2_ok;
    logic [XW-1:0]      r_s2_ix;
    logic [YW-1:0]      r_s2_iy;
    logic [F-1:0]       r_s2_rx;
    logic [F-1:0]       r_s2_ry;
    logic [WW-1:0]      r_s2_qx;
    logic [WW-1:0]      r_s2_qy;
    logic [AW0-1:0]     r_s2_ra0_lo;
    logic [AW0-1:0]     r_s2_ra0_hi;
    logic [AW1-1:0]     r_s2_ra1_lo;
    logic [AW1-1:0]     r_s2_ra1_hi;
    logic               r_s2_we0;
    logic               r_s2_we1;
    logic [AW0-1:0]     r_s2_wa0;
    logic [AW1-1:0]     r_s2_wa1;
    logic signed [31:0] r_s2_wd;

    logic [IW-1:0]  ix_full;
    logic [IW-1:0]  iy_full;
    logic [F-1:0]   rx;
    logic [F-1:0]   ry;
    logic [31:0]    wrap32;
    logic           ok;
    logic [XW-1:0]  ix;
    logic [YW-1:0]  iy;
    logic [XW:0]    ix_inc;
    logic [XW-1:0]  x1;
    logic [YW:0]    iy_inc;
    logic [YW:0]    iy_ext;
    logic [31:0]    row0_32;
    logic [31:0]    row1_32;
    logic [31:0]    cx32;
    logic [31:0]    cy32;
    logic [31:0]    cyh32;

    always_comb begin
        ix_full = r_s1_prod_x[63:2*F];
        iy_full = r_s1_prod_y[63:2*F];
        rx      = r_s1_prod_x[2*F-1:F];
        ry      = r_s1_prod_y[2*F-1:F];

        // Clamp the wrap modulus to 1..GRID_W
        wrap32 = 32'(i_cfg.wrap);
        if (wrap32 == 32'd0) begin
            wrap32 = 32'd1;
        end else if (wrap32 > 32'(GRID_W)) begin
            wrap32 = 32'(GRID_W);
        end

        ok = !(r_s1_neg_x && (r_s1_prod_x != 64'd0))
          && !(r_s1_neg_y && (r_s1_prod_y != 64'd0))
          && (64'(ix_full) < 64'(wrap32))
          && (64'(iy_full) < 64'(GRID_H - 1));

        ix     = ix_full[XW-1:0];
        iy     = iy_full[YW-1:0];
        ix_inc = {1'b0, ix} + 1'b1;
        x1     = (ix_inc == wrap32[XW:0]) ? '0 : ix_inc[XW-1:0];

        // Bank 0 holds the even one of (iy, iy+1), bank 1 the odd one
        iy_inc  = {1'b0, iy} + 1'b1;
        iy_ext  = {1'b0, iy};
        row0_32 = 32'(iy_inc[YW:1]);
        row1_32 = 32'(iy_ext[YW:1]);

        cx32  = 32'(r_s1_cell_x);
        cy32  = 32'(r_s1_cell_y);
        cyh32 = cy32 >> 1;
    end

    // ---- stage 3: bank read data and weights
    logic               r_s3_v;
    logic               r_s3_ok;
    logic [XW-1:0]      r_s3_ix;
    logic [YW-1:0]      r_s3_iy;
    logic [WW-1:0]      r_s3_w00;
    logic [WW-1:0]      r_s3_w01;
    logic [WW-1:0]      r_s3_w10;
    logic [WW-1:0]      r_s3_w11;
    logic signed [31:0] r_rd0_lo;
    logic signed [31:0] r_rd0_hi;
    logic signed [31:0] r_rd1_lo;
    logic signed [31:0] r_rd1_hi;

    logic [PQW-1:0] p00;
    logic [PQW-1:0] p01;
    logic [PQW-1:0] p10;
    logic [PQW-1:0] p11;

    always_comb begin
        p00 = PQW'(r_s2_qx) * PQW'(r_s2_qy);
        p01 = PQW'(r_s2_qx) * PQW'(r_s2_ry);
        p10 = PQW'(r_s2_rx) * PQW'(r_s2_qy);
        p11 = PQW'(r_s2_rx) * PQW'(r_s2_ry);
    end

    // ---- stage 4: weighted products
    logic              r_s4_v;
    logic              r_s4_ok;
    logic [XW-1:0]     r_s4_ix;
    logic [YW-1:0]     r_s4_iy;
    logic [WW-1:0]     r_s4_w00;
    logic [WW-1:0]     r_s4_w01;
    logic [WW-1:0]     r_s4_w10;
    logic [WW-1:0]     r_s4_w11;
    logic signed [PW-1:0] r_s4_m00;
    logic signed [PW-1:0] r_s4_m01;
    logic signed [PW-1:0] r_s4_m10;
    logic signed [PW-1:0] r_s4_m11;

    logic signed [31:0] c00;
    logic signed [31:0] c01;
    logic signed [31:0] c10;
    logic signed [31:0] c11;

    always_comb begin
        if (r_s3_iy[0]) begin
            c00 = r_rd1_lo;
            c01 = r_rd0_lo;
            c10 = r_rd1_hi;
            c11 = r_rd0_hi;
        end else begin
            c00 = r_rd0_lo;
            c01 = r_rd1_lo;
            c10 = r_rd0_hi;
            c11 = r_rd1_hi;
        end
    end

    // ---- stage 5: sum, floor shift, zero when out of range
    logic               r_valid;
    bfg_pkg::t_result   r_result;

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shf;
    logic [31:0]          ix32;
    logic [31:0]          iy32;
    logic [31:0]          w00_32;
    logic [31:0]          w01_32;
    logic [31:0]          w10_32;
    logic [31:0]          w11_32;

    always_comb begin
        sum    = SW'(r_s4_m00) + SW'(r_s4_m01) + SW'(r_s4_m10) + SW'(r_s4_m11);
        shf    = sum >>> F;
        ix32   = 32'(r_s4_ix);
        iy32   = 32'(r_s4_iy);
        w00_32 = 32'(r_s4_w00);
        w01_32 = 32'(r_s4_w01);
        w10_32 = 32'(r_s4_w10);
        w11_32 = 32'(r_s4_w11);
    end

    // ---- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s2_we0 <= 1'b0;
            r_s2_we1 <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_s1_v   <= i_valid;
            r_s2_v   <= r_s1_v && r_s1_interp;
            r_s2_we0 <= r_s1_v && r_s1_load && !r_s1_cell_y[0];
            r_s2_we1 <= r_s1_v && r_s1_load && r_s1_cell_y[0];
            r_s3_v   <= r_s2_v;
            r_s4_v   <= r_s3_v;
            r_valid  <= r_s4_v;
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        // stage 1
        r_s1_interp     <= i_item.interp;
        r_s1_load       <= i_item.load_ok && !i_item.interp;
        r_s1_prod_x     <= {32'd0, mag_x} * {32'd0, i_cfg.inv_x};
        r_s1_prod_y     <= {32'd0, mag_y} * {32'd0, i_cfg.inv_y};
        r_s1_neg_x      <= i_item.d_x[32];
        r_s1_neg_y      <= i_item.d_y[32];
        r_s1_cell_x     <= i_item.cell_x;
        r_s1_cell_y     <= i_item.cell_y;
        r_s1_cell_value <= i_item.cell_value;

        // stage 2
        r_s2_ok     <= ok;
        r_s2_ix     <= ix;
        r_s2_iy     <= iy;
        r_s2_rx     <= rx;
        r_s2_ry     <= ry;
        r_s2_qx     <= ONE_W - {1'b0, rx};
        r_s2_qy     <= ONE_W - {1'b0, ry};
        r_s2_ra0_lo <= {row0_32[RW0-1:0], ix};
        r_s2_ra0_hi <= {row0_32[RW0-1:0], x1};
        r_s2_ra1_lo <= {row1_32[RW1-1:0], ix};
        r_s2_ra1_hi <= {row1_32[RW1-1:0], x1};
        r_s2_wa0    <= {cyh32[RW0-1:0], cx32[XW-1:0]};
        r_s2_wa1    <= {cyh32[RW1-1:0], cx32[XW-1:0]};
        r_s2_wd     <= r_s1_cell_value;

        // stage 3
        r_s3_ok  <= r_s2_ok;
        r_s3_ix  <= r_s2_ix;
        r_s3_iy  <= r_s2_iy;
        r_s3_w00 <= p00[2*F:F];
        r_s3_w01 <= p01[2*F:F];
        r_s3_w10 <= p10[2*F:F];
        r_s3_w11 <= p11[2*F:F];

        // stage 4
        r_s4_ok  <= r_s3_ok;
        r_s4_ix  <= r_s3_ix;
        r_s4_iy  <= r_s3_iy;
        r_s4_w00 <= r_s3_w00;
        r_s4_w01 <= r_s3_w01;
        r_s4_w10 <= r_s3_w10;
        r_s4_w11 <= r_s3_w11;
        r_s4_m00 <= $signed({1'b0, r_s3_w00}) * c00;
        r_s4_m01 <= $signed({1'b0, r_s3_w01}) * c01;
        r_s4_m10 <= $signed({1'b0, r_s3_w10}) * c10;
        r_s4_m11 <= $signed({1'b0, r_s3_w11}) * c11;

        // stage 5
        if (r_s4_ok) begin
            r_result.field_value  <= shf[31:0];
            r_result.index_x      <= ix32[5:0];
            r_result.index_y      <= iy32[5:0];
            r_result.weight_00    <= w00_32[16:0];
            r_result.weight_01    <= w01_32[16:0];
            r_result.weight_10    <= w10_32[16:0];
            r_result.weight_11    <= w11_32[16:0];
            r_result.out_of_range <= 1'b0;
        end else begin
            r_result.field_value  <= '0;
            r_result.index_x      <= '0;
            r_result.index_y      <= '0;
            r_result.weight_00    <= '0;
            r_result.weight_01    <= '0;
            r_result.weight_10    <= '0;
            r_result.weight_11    <= '0;
            r_result.out_of_range <= 1'b1;
        end
    end

    // ---- row banks: one write and two reads each per cycle
    always_ff @(posedge i_clk) begin
        if (r_s2_we0) begin
            r_bank0[r_s2_wa0] <= r_s2_wd;
        end
        r_rd0_lo <= r_bank0[r_s2_ra0_lo];
        r_rd0_hi <= r_bank0[r_s2_ra0_hi];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_we1) begin
            r_bank1[r_s2_wa1] <= r_s2_wd;
        end
        r_rd1_lo <= r_bank1[r_s2_ra1_lo];
        r_rd1_hi <= r_bank1[r_s2_ra1_hi];
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
